@@ sv/packed_pixel_palette_expander_defines.svh @@
// Assertion macros shared by the palette expander RTL.
`ifndef PACKED_PIXEL_PALETTE_EXPANDER_DEFINES_SVH
`define PACKED_PIXEL_PALETTE_EXPANDER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PPE_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ppe check failed");

// Next-cycle implication, checked out of reset.
`define PPE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ppe check failed");

`endif

@@ sv/ppe_pkg.sv @@
// Types, constants and helper functions for the packed pixel palette expander.
package ppe_pkg;

  localparam int unsigned PPE_TABLE_ENTRIES = 256;
  localparam int unsigned PPE_CFG_IDX_W     = 4;
  localparam int unsigned PPE_CFG_DATA_W    = 16;

  // Configuration register indexes
  localparam logic [PPE_CFG_IDX_W-1:0] CFG_SAMPLE_BITS = 4'd0;
  localparam logic [PPE_CFG_IDX_W-1:0] CFG_PALETTE     = 4'd1;
  localparam logic [PPE_CFG_IDX_W-1:0] CFG_INVERT      = 4'd2;
  localparam logic [PPE_CFG_IDX_W-1:0] CFG_ROW_PIXELS  = 4'd3;

  // Input beat opcodes
  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_TABLE = 1'b1;

  // Sample size codes
  localparam logic [1:0] BITS_1 = 2'd0;
  localparam logic [1:0] BITS_2 = 2'd1;
  localparam logic [1:0] BITS_4 = 2'd2;
  localparam logic [1:0] BITS_8 = 2'd3;

  typedef struct packed {
    logic [1:0]  sample_bits_code;
    logic        palette_mode;
    logic        invert_mode;
    logic [15:0] row_pixels;
  } ppe_cfg_t;

  // One sample leaving the unpacker
  typedef struct packed {
    logic       valid;
    logic [7:0] sample;
    logic       last_of_byte;
    logic       end_of_row;
  } ppe_issue_t;

  // Colour table write request
  typedef struct packed {
    logic        en;
    logic [7:0]  index;
    logic [47:0] rgb;
  } ppe_wr_t;

  // floor(x / 257): 65281 / 2^24 overshoots 1/257 by 2^-24 relative,
  // far below the 1/257 gap, so the truncated product is exact.
  function automatic logic [7:0] div257(input logic [15:0] x);
    logic [31:0] prod;
    prod = 32'(x) * 32'd65281;
    return prod[31:24];
  endfunction

endpackage

@@ sv/ppe_stream_if.sv @@
// Channel interfaces: input items, output pixels and configuration writes.
interface ppe_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  data_byte;
  logic [7:0]  table_index;
  logic [15:0] table_red;
  logic [15:0] table_green;
  logic [15:0] table_blue;

  modport source (output valid, op, data_byte, table_index, table_red, table_green,
                  table_blue, input ready);
  modport sink   (input valid, op, data_byte, table_index, table_red, table_green,
                  table_blue, output ready);
endinterface

interface ppe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_red_or_gray;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  logic       last_of_byte;
  logic       end_of_row;

  modport source (output valid, pixel_red_or_gray, pixel_green, pixel_blue, last_of_byte,
                  end_of_row, input ready);
  modport sink   (input valid, pixel_red_or_gray, pixel_green, pixel_blue, last_of_byte,
                  end_of_row, output ready);
endinterface

interface ppe_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ppe_pkg::PPE_CFG_IDX_W-1:0]  index;
  logic [ppe_pkg::PPE_CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/ppe_cfg_regs.sv @@
// Configuration register file of the palette expander.
module ppe_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  ppe_cfg_if.sink           cfg_ch,
  output ppe_pkg::ppe_cfg_t cfg
);
  import ppe_pkg::*;

  ppe_cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  // Register write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_bits_code <= BITS_8;
      cfg_r.palette_mode     <= 1'b0;
      cfg_r.invert_mode      <= 1'b0;
      cfg_r.row_pixels       <= 16'd1;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_SAMPLE_BITS: cfg_r.sample_bits_code <= cfg_ch.data[1:0];
        CFG_PALETTE:     cfg_r.palette_mode     <= cfg_ch.data[0];
        CFG_INVERT:      cfg_r.invert_mode      <= cfg_ch.data[0];
        CFG_ROW_PIXELS:  cfg_r.row_pixels       <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

endmodule

@@ sv/ppe_unpack.sv @@
// Byte unpacker: holds one input beat and issues its samples one per cycle while the output stage advances.
`include "packed_pixel_palette_expander_defines.svh"

module ppe_unpack (
  input  logic                clk,
  input  logic                rst_n,
  ppe_in_if.sink              in_ch,
  input  ppe_pkg::ppe_cfg_t   cfg,
  input  logic                adv,
  output ppe_pkg::ppe_issue_t issue,
  output ppe_pkg::ppe_wr_t    wr
);
  import ppe_pkg::*;

  logic        busy_r;
  logic        is_wr_r;
  logic [7:0]  shreg_r;
  logic [2:0]  k_r;
  logic [15:0] pos_r;
  logic [7:0]  widx_r;
  logic [47:0] wrgb_r;

  logic [15:0] width;
  logic [15:0] pos_eff;
  logic [16:0] pos_inc;
  logic        row_end;
  logic        k_last;
  logic [3:0]  nbits;
  logic [7:0]  sample;
  logic        step;
  logic        done;
  logic        in_fire;

  // Row position: a width of zero acts as one, a stale position restarts the row
  always_comb begin
    width   = (cfg.row_pixels == 16'd0) ? 16'd1 : cfg.row_pixels;
    pos_eff = (pos_r >= width) ? 16'd0 : pos_r;
    pos_inc = {1'b0, pos_eff} + 17'd1;
    row_end = (pos_inc == {1'b0, width});
    k_last  = (k_r == (3'd7 >> cfg.sample_bits_code));
    nbits   = 4'd1 << cfg.sample_bits_code;
  end

  // Current sample sits in the top bits of the shift register
  always_comb begin
    unique case (cfg.sample_bits_code)
      BITS_1:  sample = {7'd0, shreg_r[7]};
      BITS_2:  sample = {6'd0, shreg_r[7:6]};
      BITS_4:  sample = {4'd0, shreg_r[7:4]};
      default: sample = shreg_r;
    endcase
  end

  assign issue.valid        = busy_r && !is_wr_r;
  assign issue.sample       = sample;
  assign issue.last_of_byte = k_last || row_end;
  assign issue.end_of_row   = row_end;

  assign wr.en    = busy_r && is_wr_r;
  assign wr.index = widx_r;
  assign wr.rgb   = wrgb_r;

  // Beat hand-off: a table write retires in the cycle it is held, a data byte on its last sample
  assign step        = issue.valid && adv;
  assign done        = wr.en || (step && issue.last_of_byte);
  assign in_ch.ready = !busy_r || done;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= 16'd0;
    end else begin
      if (in_fire) begin
        busy_r <= 1'b1;
      end else if (done) begin
        busy_r <= 1'b0;
      end
      if (step) begin
        pos_r <= row_end ? 16'd0 : pos_inc[15:0];
      end
    end
  end

  // Beat payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      is_wr_r <= (in_ch.op == OP_TABLE);
      shreg_r <= in_ch.data_byte;
      k_r     <= 3'd0;
      widx_r  <= in_ch.table_index;
      wrgb_r  <= {in_ch.table_red, in_ch.table_green, in_ch.table_blue};
    end else if (step) begin
      shreg_r <= 8'(shreg_r << nbits);
      k_r     <= k_r + 3'd1;
    end
  end

  `PPE_ASSERT_NOW(a_eor_ends_byte, issue.valid && issue.end_of_row, issue.last_of_byte)
  `PPE_ASSERT_NOW(a_one_access, wr.en, !issue.valid)
  `PPE_ASSERT_NEXT(a_retire, done && !in_fire, !busy_r)
  `PPE_ASSERT_NEXT(a_pos_in_row, step, pos_r < width)

endmodule

@@ sv/ppe_palette_mem.sv @@
// Colour table memory: one write port, one registered read port.
module ppe_palette_mem #(
  parameter int unsigned TABLE_ENTRIES = ppe_pkg::PPE_TABLE_ENTRIES
) (
  input  logic             clk,
  input  ppe_pkg::ppe_wr_t wr,
  input  logic [7:0]       rd_index,
  input  logic             rd_en,
  output logic [47:0]      rd_rgb
);
  import ppe_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);

  logic [47:0] mem [TABLE_ENTRIES];
  logic [47:0] rdata_r;
  logic        hit_r;
  logic        wr_hit;
  logic        rd_hit;

  // Indexes past the table: writes dropped, reads give black
  assign wr_hit = ({1'b0, wr.index} < 9'(TABLE_ENTRIES));
  assign rd_hit = ({1'b0, rd_index} < 9'(TABLE_ENTRIES));

  always_ff @(posedge clk) begin
    if (wr.en && wr_hit) begin
      mem[wr.index[AW-1:0]] <= wr.rgb;
    end
  end

  // Read data holds while the pipeline is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_index[AW-1:0]];
      hit_r   <= rd_hit;
    end
  end

  assign rd_rgb = hit_r ? rdata_r : 48'd0;

endmodule

@@ sv/ppe_out_stage.sv @@
// Read stage and output register: colour scaling, gray scaling and result beat.
module ppe_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  ppe_pkg::ppe_issue_t issue,
  input  ppe_pkg::ppe_cfg_t   cfg,
  input  logic [47:0]         rgb,
  output logic                adv,
  ppe_out_if.source           out_ch
);
  import ppe_pkg::*;

  logic       vb_r;
  logic [7:0] sb_r;
  logic       lob_b_r;
  logic       eor_b_r;
  logic       out_valid_r;
  logic [7:0] red_r;
  logic [7:0] green_r;
  logic [7:0] blue_r;
  logic       lob_r;
  logic       eor_r;

  logic       en_c;
  logic [7:0] gray;
  logic [7:0] red_nxt;
  logic [7:0] green_nxt;
  logic [7:0] blue_nxt;

  assign en_c = !out_valid_r || out_ch.ready;
  assign adv  = !vb_r || en_c;

  // b*255/max is exact bit replication for 1, 2, 4 and 8 bit samples
  always_comb begin
    unique case (cfg.sample_bits_code)
      BITS_1:  gray = {8{sb_r[0]}};
      BITS_2:  gray = {4{sb_r[1:0]}};
      BITS_4:  gray = {2{sb_r[3:0]}};
      default: gray = sb_r;
    endcase
    if (cfg.palette_mode) begin
      red_nxt   = div257(rgb[47:32]);
      green_nxt = div257(rgb[31:16]);
      blue_nxt  = div257(rgb[15:0]);
    end else begin
      red_nxt   = cfg.invert_mode ? ~gray : gray;
      green_nxt = 8'd0;
      blue_nxt  = 8'd0;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        vb_r <= issue.valid;
      end
      if (en_c) begin
        out_valid_r <= vb_r;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r    <= issue.sample;
      lob_b_r <= issue.last_of_byte;
      eor_b_r <= issue.end_of_row;
    end
    if (en_c) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      lob_r   <= lob_b_r;
      eor_r   <= eor_b_r;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.pixel_red_or_gray = red_r;
  assign out_ch.pixel_green       = green_r;
  assign out_ch.pixel_blue        = blue_r;
  assign out_ch.last_of_byte      = lob_r;
  assign out_ch.end_of_row        = eor_r;

endmodule

@@ sv/packed_pixel_palette_expander.sv @@
// Top level of the packed pixel palette expander.
//
//   channel  | dir | beat carries
//   ---------+-----+------------------------------------------------------
//   in_ch    | in  | data byte of packed samples, or one colour table write
//   out_ch   | out | one 8-bit pixel (red/gray, green, blue) with byte/row flags
//   cfg_ch   | in  | register index and write data, always ready
//
// One pixel per cycle while the output is not stalled: a data byte yields 1 to
// 8 pixels, a table write none; the unpacker issues one sample per cycle. An
// input beat passes the unpack, table read and output register stages in order.
// Synchronous active-low reset clears the valid bits and the row position and
// loads the configuration defaults; the colour table and payload registers are
// not cleared. A stalled output holds the pipe once the table read stage is
// full; a new beat is taken in the cycle the previous byte issues its last sample.
module packed_pixel_palette_expander #(
  parameter int unsigned TABLE_ENTRIES = ppe_pkg::PPE_TABLE_ENTRIES
) (
  input logic       clk,
  input logic       rst_n,
  ppe_in_if.sink    in_ch,
  ppe_out_if.source out_ch,
  ppe_cfg_if.sink   cfg_ch
);
  import ppe_pkg::*;

  ppe_cfg_t    cfg;
  ppe_issue_t  issue;
  ppe_wr_t     wr;
  logic        adv;
  logic [47:0] rgb;

  ppe_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  ppe_unpack u_unpack (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .cfg   (cfg),
    .adv   (adv),
    .issue (issue),
    .wr    (wr)
  );

  ppe_palette_mem #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_mem (
    .clk      (clk),
    .wr       (wr),
    .rd_index (issue.sample),
    .rd_en    (adv),
    .rd_rgb   (rgb)
  );

  ppe_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .issue  (issue),
    .cfg    (cfg),
    .rgb    (rgb),
    .adv    (adv),
    .out_ch (out_ch)
  );

endmodule
